/* hw/rtl/segi_pkg.sv */
package segi_pkg;

    localparam int CW = 32;               // coordinate bits
    localparam int FB = 30;               // parameter fraction bits
    localparam int QB = 32;               // quotient / parameter bits
    localparam int DW = 2 * CW + 3;       // signed determinant and numerator width
    localparam int MW = DW;               // magnitude width
    localparam int TW = 30;               // parameter tolerance width
    localparam int IN_W = 8 * CW;
    localparam int OUT_W = 136;

    localparam logic [1:0] OC_HIT  = 2'd0;
    localparam logic [1:0] OC_PAR  = 2'd1;
    localparam logic [1:0] OC_OUT1 = 2'd2;
    localparam logic [1:0] OC_OUT2 = 2'd3;

    localparam logic signed [CW:0] ONE_Q = (CW + 1)'(1) << FB;

    typedef struct packed {
        logic          neg;
        logic          ovf;
        logic [MW-1:0] rem;
        logic [QB-1:0] nsh;
        logic [QB-1:0] q;
    } div_t;

    typedef struct packed {
        logic          valid;
        logic          par;
        logic [CW-1:0] x0;
        logic [CW-1:0] y0;
        logic [CW:0]   dx;
        logic [CW:0]   dy;
        logic [MW-1:0] den;
        div_t          a;
        div_t          b;
    } cell_t;

    typedef struct packed {
        logic          valid;
        logic [1:0]    outcome;
        logic [CW-1:0] p1;
        logic [CW-1:0] p2;
        logic [CW-1:0] cx;
        logic [CW-1:0] cy;
    } res_t;

endpackage

/* hw/rtl/segi_front.sv */
module segi_front
    import segi_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [IN_W-1:0] in_data,
    input  logic [CW-1:0]   area_tol,
    output cell_t           out
);

    function automatic logic signed [CW:0] sdiff(logic [CW-1:0] p, logic [CW-1:0] q);
        return $signed({p[CW-1], p}) - $signed({q[CW-1], q});
    endfunction

    logic [CW-1:0] x11, y11, x12, y12, x21, y21, x22, y22;

    // stage 0: differences
    logic               s0_valid_reg;
    logic signed [CW:0] da_reg, db_reg, dc_reg, de_reg, df_reg, dg_reg, dh_reg;
    logic signed [CW:0] dx0_reg, dy0_reg;
    logic [CW-1:0]      x0_0_reg, y0_0_reg;

    // stage 1: products
    logic                      s1_valid_reg;
    logic signed [2*CW+1:0]    pab_reg, pce_reg, pfg_reg, phe_reg, phb_reg, pxg_reg;
    logic signed [CW:0]        dx1_reg, dy1_reg;
    logic [CW-1:0]             x0_1_reg, y0_1_reg;

    // stage 2: sums
    logic                 s2_valid_reg;
    logic signed [DW-1:0] det_reg, n1_reg, n2_reg;
    logic signed [CW:0]   dx2_reg, dy2_reg;
    logic [CW-1:0]        x0_2_reg, y0_2_reg;

    // stage 3: magnitudes
    logic               s3_valid_reg;
    logic               par_reg, neg1_reg, neg2_reg;
    logic [MW-1:0]      md_reg, m1_reg, m2_reg;
    logic signed [CW:0] dx3_reg, dy3_reg;
    logic [CW-1:0]      x0_3_reg, y0_3_reg;

    cell_t out_reg, out_next;

    logic [MW-1:0] dmag, mag1, mag2, r1, r2;

    assign x11 = in_data[0*CW +: CW];
    assign y11 = in_data[1*CW +: CW];
    assign x12 = in_data[2*CW +: CW];
    assign y12 = in_data[3*CW +: CW];
    assign x21 = in_data[4*CW +: CW];
    assign y21 = in_data[5*CW +: CW];
    assign x22 = in_data[6*CW +: CW];
    assign y22 = in_data[7*CW +: CW];

    assign dmag = det_reg[DW-1] ? MW'(-det_reg) : MW'(det_reg);
    assign mag1 = n1_reg[DW-1] ? MW'(-n1_reg) : MW'(n1_reg);
    assign mag2 = n2_reg[DW-1] ? MW'(-n2_reg) : MW'(n2_reg);

    assign r1 = m1_reg >> (QB - FB);
    assign r2 = m2_reg >> (QB - FB);

    always_comb
    begin
        out_next          = '0;
        out_next.valid    = s3_valid_reg;
        out_next.par      = par_reg;
        out_next.x0       = x0_3_reg;
        out_next.y0       = y0_3_reg;
        out_next.dx       = dx3_reg;
        out_next.dy       = dy3_reg;
        out_next.den      = md_reg;
        out_next.a.neg    = neg1_reg;
        out_next.a.ovf    = r1 >= md_reg;
        out_next.a.rem    = r1;
        out_next.a.nsh    = QB'(m1_reg) << FB;
        out_next.b.neg    = neg2_reg;
        out_next.b.ovf    = r2 >= md_reg;
        out_next.b.rem    = r2;
        out_next.b.nsh    = QB'(m2_reg) << FB;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            out_reg      <= '0;
        end
        else if (en)
        begin
            s0_valid_reg <= in_valid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            out_reg      <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            da_reg   <= sdiff(x21, x22);
            db_reg   <= sdiff(y11, y12);
            dc_reg   <= sdiff(x11, x12);
            de_reg   <= sdiff(y21, y22);
            df_reg   <= sdiff(x22, x21);
            dg_reg   <= sdiff(y21, y11);
            dh_reg   <= sdiff(x21, x11);
            dx0_reg  <= sdiff(x12, x11);
            dy0_reg  <= sdiff(y12, y11);
            x0_0_reg <= x11;
            y0_0_reg <= y11;

            pab_reg  <= da_reg * db_reg;
            pce_reg  <= dc_reg * de_reg;
            pfg_reg  <= df_reg * dg_reg;
            phe_reg  <= dh_reg * de_reg;
            phb_reg  <= dh_reg * db_reg;
            pxg_reg  <= dx0_reg * dg_reg;
            dx1_reg  <= dx0_reg;
            dy1_reg  <= dy0_reg;
            x0_1_reg <= x0_0_reg;
            y0_1_reg <= y0_0_reg;

            det_reg  <= $signed({pab_reg[2*CW+1], pab_reg}) - $signed({pce_reg[2*CW+1], pce_reg});
            n1_reg   <= $signed({pfg_reg[2*CW+1], pfg_reg}) + $signed({phe_reg[2*CW+1], phe_reg});
            n2_reg   <= $signed({phb_reg[2*CW+1], phb_reg}) + $signed({pxg_reg[2*CW+1], pxg_reg});
            dx2_reg  <= dx1_reg;
            dy2_reg  <= dy1_reg;
            x0_2_reg <= x0_1_reg;
            y0_2_reg <= y0_1_reg;

            md_reg   <= dmag;
            m1_reg   <= mag1;
            m2_reg   <= mag2;
            par_reg  <= (dmag == '0) || (dmag < MW'(area_tol));
            neg1_reg <= n1_reg[DW-1] ^ det_reg[DW-1];
            neg2_reg <= n2_reg[DW-1] ^ det_reg[DW-1];
            dx3_reg  <= dx2_reg;
            dy3_reg  <= dy2_reg;
            x0_3_reg <= x0_2_reg;
            y0_3_reg <= y0_2_reg;
        end
    end

    assign out = out_reg;

endmodule

/* hw/rtl/segi_div_cell.sv */
module segi_div_cell
    import segi_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  cell_t din,
    output cell_t dout
);

    function automatic div_t step(div_t d, logic [MW-1:0] den);
        logic [MW:0] r2;
        logic        ge;
        div_t        o;
        r2    = {d.rem, d.nsh[QB-1]};
        ge    = r2 >= {1'b0, den};
        o     = d;
        o.rem = ge ? MW'(r2 - {1'b0, den}) : MW'(r2);
        o.q   = {d.q[QB-2:0], ge};
        o.nsh = d.nsh << 1;
        return o;
    endfunction

    cell_t cell_reg, cell_next;

    always_comb
    begin
        cell_next   = din;
        cell_next.a = step(din.a, din.den);
        cell_next.b = step(din.b, din.den);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_reg <= '0;
        else if (en)
            cell_reg <= cell_next;
    end

    assign dout = cell_reg;

endmodule

/* hw/rtl/segi_back.sv */
module segi_back
    import segi_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  cell_t         din,
    input  logic [TW-1:0] param_tol,
    output res_t          out
);

    function automatic logic [CW-1:0] sat_param(div_t d);
        logic [QB-1:0] lim;
        logic [QB-1:0] m;
        lim = d.neg ? (QB'(1) << (CW - 1)) : ((QB'(1) << (CW - 1)) - QB'(1));
        m   = (d.ovf || d.q > lim) ? lim : d.q;
        return d.neg ? CW'(-m) : CW'(m);
    endfunction

    function automatic logic outside(logic [CW-1:0] p, logic [TW-1:0] tol);
        logic signed [CW:0] pe;
        logic signed [CW:0] tl;
        pe = $signed({p[CW-1], p});
        tl = $signed((CW + 1)'(tol));
        return (pe <= -tl) || (pe >= ONE_Q + tl);
    endfunction

    function automatic logic [CW-1:0] cross_sat(logic [CW-1:0] base,
                                                logic signed [2*CW:0] prod);
        logic signed [CW+3:0] s;
        s = $signed({{4{base[CW-1]}}, base}) + $signed((CW + 4)'(prod >>> FB));
        if (s > $signed((CW + 4)'({1'b0, {(CW - 1){1'b1}}})))
            return {1'b0, {(CW - 1){1'b1}}};
        else if (s < -$signed((CW + 4)'({1'b1, {(CW - 1){1'b0}}})))
            return {1'b1, {(CW - 1){1'b0}}};
        else
            return s[CW-1:0];
    endfunction

    // stage 0: saturation and window tests
    logic          v0_reg;
    logic [1:0]    oc0_reg;
    logic [CW-1:0] p1_0_reg, p2_0_reg, x0_0_reg, y0_0_reg;
    logic [CW:0]   dx_reg, dy_reg;
    // stage 1: scaled offsets
    logic                  v1_reg;
    logic [1:0]            oc1_reg;
    logic [CW-1:0]         p1_1_reg, p2_1_reg, x0_1_reg, y0_1_reg;
    logic signed [2*CW:0]  mx_reg, my_reg;

    res_t out_reg, out_next;

    logic [CW-1:0] p1, p2;
    logic          o1, o2;
    logic [1:0]    oc;

    always_comb
    begin
        p1 = sat_param(din.a);
        p2 = sat_param(din.b);
        o1 = outside(p1, param_tol);
        o2 = outside(p2, param_tol);
        priority if (din.par)
            oc = OC_PAR;
        else if (o1)
            oc = OC_OUT1;
        else if (o2)
            oc = OC_OUT2;
        else
            oc = OC_HIT;
    end

    always_comb
    begin
        out_next.valid   = v1_reg;
        out_next.outcome = oc1_reg;
        out_next.p1      = p1_1_reg;
        out_next.p2      = p2_1_reg;
        out_next.cx      = (oc1_reg == OC_HIT) ? cross_sat(x0_1_reg, mx_reg) : '0;
        out_next.cy      = (oc1_reg == OC_HIT) ? cross_sat(y0_1_reg, my_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg  <= 1'b0;
            v1_reg  <= 1'b0;
            out_reg <= '0;
        end
        else if (en)
        begin
            v0_reg  <= din.valid;
            v1_reg  <= v0_reg;
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oc0_reg  <= oc;
            p1_0_reg <= (oc == OC_PAR) ? '0 : p1;
            p2_0_reg <= (oc == OC_HIT || oc == OC_OUT2) ? p2 : '0;
            x0_0_reg <= din.x0;
            y0_0_reg <= din.y0;
            dx_reg   <= din.dx;
            dy_reg   <= din.dy;

            oc1_reg  <= oc0_reg;
            p1_1_reg <= p1_0_reg;
            p2_1_reg <= p2_0_reg;
            x0_1_reg <= x0_0_reg;
            y0_1_reg <= y0_0_reg;
            mx_reg   <= $signed(p1_0_reg) * $signed(dx_reg);
            my_reg   <= $signed(p1_0_reg) * $signed(dy_reg);
        end
    end

    assign out = out_reg;

endmodule

/* hw/rtl/segment_intersection_2d.sv */
// Segment pair intersection. One pair of segments per beat, accepted every cycle
// while s_tready is high; s_tready drops while the output skid register holds a beat.
// The path holds 41 register stages: five front stages (differences, products,
// determinant, magnitudes, divider setup), the 32-cell divider chain that produces
// one quotient bit of both parameters per cell, three back stages (saturation and
// window test, crossing product, final add) and the output register. Config writes
// take effect at once and should only be made while no beats are in flight.
module segment_intersection_2d
    import segi_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // first_start_x, first_start_y, first_end_x, first_end_y,
    // second_start_x, second_start_y, second_end_x, second_end_y
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // outcome, first_param, second_param, cross_x, cross_y, zero pad
    output logic [OUT_W-1:0] m_tdata,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data
);

    localparam logic [1:0] REG_AREA_TOL  = 2'd0;
    localparam logic [1:0] REG_PARAM_TOL = 2'd1;

    logic [CW-1:0] area_tol_reg;
    logic [TW-1:0] param_tol_reg;

    logic en;
    res_t res;
    res_t out_reg, skid_reg;
    logic skid_valid_reg;

    cell_t chain [0:QB];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_tol_reg  <= CW'(1);
            param_tol_reg <= TW'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_AREA_TOL:  area_tol_reg  <= cfg_data[CW-1:0];
                REG_PARAM_TOL: param_tol_reg <= cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    segi_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .in_data  (s_tdata),
        .area_tol (area_tol_reg),
        .out      (chain[0])
    );

    for (genvar i = 0; i < QB; i++)
    begin : g_cell
        segi_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .din   (chain[i]),
            .dout  (chain[i+1])
        );
    end

    segi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .din       (chain[QB]),
        .param_tol (param_tol_reg),
        .out       (res)
    );

    // output register plus skid beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg        <= '0;
            skid_reg       <= '0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_reg.valid || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
            else if (en && res.valid)
                out_reg <= res;
            else
                out_reg.valid <= 1'b0;
        end
        else if (en && res.valid)
        begin
            skid_reg       <= res;
            skid_valid_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_reg.valid;
    assign m_tdata  = {6'b0, out_reg.cy, out_reg.cx, out_reg.p2, out_reg.p1, out_reg.outcome};

endmodule

/* verif/tb_top.sv */
module tb_top;
    import segi_pkg::*;

    localparam logic [1:0] REG_AREA_TOL  = 2'd0;
    localparam logic [1:0] REG_PARAM_TOL = 2'd1;
    localparam logic [1:0] REG_SPARE_A   = 2'd2;
    localparam logic [1:0] REG_SPARE_B   = 2'd3;
    localparam int PIPE_LAT = 40;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [31:0] p1;
        logic [31:0] p2;
        logic [31:0] cx;
        logic [31:0] cy;
    } crossing_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [1:0]        cfg_index;
    logic [31:0]       cfg_data;

    logic [31:0] area_tol;
    logic [29:0] param_tol;
    crossing_t   pending_q[$];
    int          fail_count;
    int          hold_cycles;
    bit          no_idle;

    segment_intersection_2d dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #600000;
        $display("tb_top failed");
        $finish;
    end

    // trunc(num * 2^FB / den), saturated to signed 32 bits
    function automatic logic signed [63:0] param_div(logic signed [129:0] num,
                                                     logic signed [129:0] den);
        logic                neg;
        logic signed [129:0] n;
        logic signed [129:0] d;
        logic signed [129:0] q;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = (n <<< FB) / d;
        if (neg)
        begin
            if (q > 130'sd2147483648) q = 130'sd2147483648;
            return -64'(q);
        end
        if (q > 130'sd2147483647) q = 130'sd2147483647;
        return 64'(q);
    endfunction

    function automatic logic [31:0] cross_coord(logic signed [129:0] base,
                                                logic signed [129:0] delta,
                                                logic signed [63:0] p);
        logic signed [129:0] pw;
        logic signed [129:0] s;
        pw = p;
        s = base + ((pw * delta) >>> FB);
        if (s > 130'sd2147483647) return 32'h7fff_ffff;
        if (s < -130'sd2147483648) return 32'h8000_0000;
        return s[31:0];
    endfunction

    function automatic crossing_t predict_pair(logic [IN_W-1:0] d);
        logic signed [129:0] x11, y11, x12, y12, x21, y21, x22, y22;
        logic signed [129:0] det, mag, n1, n2, atol;
        logic signed [63:0]  p1, p2, tol, one;
        crossing_t r;
        x11 = $signed(d[31:0]);    y11 = $signed(d[63:32]);
        x12 = $signed(d[95:64]);   y12 = $signed(d[127:96]);
        x21 = $signed(d[159:128]); y21 = $signed(d[191:160]);
        x22 = $signed(d[223:192]); y22 = $signed(d[255:224]);
        tol = $signed({34'd0, param_tol});
        one = 64'sd1 <<< FB;
        atol = $signed({98'd0, area_tol});
        r = '0;
        p1 = 0;
        p2 = 0;
        det = (x21 - x22) * (y11 - y12) - (x11 - x12) * (y21 - y22);
        mag = (det < 0) ? -det : det;
        if (det == 0 || mag < atol)
            r.outcome = OC_PAR;
        else
        begin
            n1 = (x22 - x21) * (y21 - y11) + (x21 - x11) * (y21 - y22);
            p1 = param_div(n1, det);
            if (p1 <= -tol || p1 >= one + tol)
                r.outcome = OC_OUT1;
            else
            begin
                n2 = (x21 - x11) * (y11 - y12) + (x12 - x11) * (y21 - y11);
                p2 = param_div(n2, det);
                if (p2 <= -tol || p2 >= one + tol)
                    r.outcome = OC_OUT2;
                else
                begin
                    r.outcome = OC_HIT;
                    r.cx = cross_coord(x11, x12 - x11, p1);
                    r.cy = cross_coord(y11, y12 - y11, p1);
                end
            end
        end
        r.p1 = p1[31:0];
        r.p2 = p2[31:0];
        return r;
    endfunction

    // result checker and receiver stall control
    always @(posedge clk)
    begin
        crossing_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_q.size() == 0)
            begin
                $error("result beat with nothing expected");
                fail_count++;
            end
            else
            begin
                e = pending_q.pop_front();
                if (m_tdata[1:0] !== e.outcome)
                begin
                    $error("outcome exp %0d got %0d", e.outcome, m_tdata[1:0]);
                    fail_count++;
                end
                if (m_tdata[33:2] !== e.p1)
                begin
                    $error("first_param exp %h got %h", e.p1, m_tdata[33:2]);
                    fail_count++;
                end
                if (m_tdata[65:34] !== e.p2)
                begin
                    $error("second_param exp %h got %h", e.p2, m_tdata[65:34]);
                    fail_count++;
                end
                if (m_tdata[97:66] !== e.cx)
                begin
                    $error("cross_x exp %h got %h", e.cx, m_tdata[97:66]);
                    fail_count++;
                end
                if (m_tdata[129:98] !== e.cy)
                begin
                    $error("cross_y exp %h got %h", e.cy, m_tdata[129:98]);
                    fail_count++;
                end
            end
        end
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= no_idle || ($urandom_range(99) >= 15);
    end

    task automatic send_pair(input logic [IN_W-1:0] d);
        while (!no_idle && $urandom_range(99) < 15)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do @(posedge clk); while (!s_tready);
        pending_q.push_back(predict_pair(d));
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (PIPE_LAT + 5) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_AREA_TOL) area_tol = val;
        else if (idx == REG_PARAM_TOL) param_tol = val[29:0];
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(2 * 65536 * 64)) - 65536 * 64);
            2: return 32'($signed($urandom_range(400)) - 200);
            default: return ($urandom_range(1)) ? 32'h7fff_ffff : 32'h8000_0000;
        endcase
    endfunction

    function automatic logic [IN_W-1:0] rand_pair();
        logic [IN_W-1:0] d;
        int m;
        int pick;
        pick = $urandom_range(99);
        m = (pick < 60) ? 1 : (pick < 80) ? 2 : (pick < 97) ? 0 : 3;
        for (int i = 0; i < 8; i++)
            d[32*i +: 32] = ($urandom_range(19) == 0) ? rand_coord($urandom_range(3))
                                                       : rand_coord(m);
        // sometimes make the pair exactly parallel or give the second start the first end's x
        if ($urandom_range(19) == 0)
        begin
            d[223:192] = d[159:128] + (d[95:64] - d[31:0]);
            d[255:224] = d[191:160] + (d[127:96] - d[63:32]);
        end
        else if ($urandom_range(19) == 0)
            d[159:128] = d[95:64];
        return d;
    endfunction

    function automatic logic [IN_W-1:0] pack8(int a, int b, int c, int e,
                                              int f, int g, int h, int k);
        return {32'(k), 32'(h), 32'(g), 32'(f), 32'(e), 32'(c), 32'(b), 32'(a)};
    endfunction

    task automatic test_directed;
        localparam int U = 65536;
        // plain X crossing
        send_pair(pack8(0, 0, 4*U, 4*U, 0, 4*U, 4*U, 0));
        // parallel and collinear
        send_pair(pack8(0, 0, 4*U, 0, 0, U, 4*U, U));
        send_pair(pack8(0, 0, 4*U, 0, U, 0, 6*U, 0));
        // degenerate segment, zero determinant
        send_pair(pack8(U, U, U, U, 0, 0, 3*U, 3*U));
        // outside first, outside second
        send_pair(pack8(0, 0, U, U, 5*U, 0, 5*U, 9*U) );
        send_pair(pack8(0, 0, 4*U, 4*U, 0, 4*U, U, 3*U));
        // touching at endpoints of the first segment: first parameters exactly zero and one
        send_pair(pack8(0, 0, 2*U, 0, 0, 0, 0, 2*U));
        send_pair(pack8(0, 0, 2*U, 0, 2*U, -U, 2*U, U));
        // near parallel, huge parameters saturate
        send_pair(pack8(0, 0, 1, 0, 0, 1, 32'h7fff_ffff, 2));
        send_pair(pack8(0, 0, 1, 0, 0, -1, 32'h8000_0000, -2));
        // coordinate extremes
        send_pair({8{32'h7fff_ffff}});
        send_pair({8{32'h8000_0000}});
        send_pair({32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                   32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000});
        send_pair({32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                   32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff});
        send_pair('0);
        send_pair({8{32'hffff_ffff}});
    endtask

    task automatic test_tolerances;
        write_reg(REG_AREA_TOL, 32'd0);
        write_reg(REG_PARAM_TOL, 32'd0);
        send_pair(pack8(0, 0, 2, 0, 0, 0, 0, 2));
        send_pair(pack8(0, 0, 0, 0, 0, 0, 1, 1));
        send_pair(pack8(0, 0, 1, 0, 0, 0, 0, 1));
        repeat (150) send_pair(rand_pair());
        write_reg(REG_AREA_TOL, 32'hffff_ffff);
        write_reg(REG_PARAM_TOL, 32'h3fff_ffff);
        repeat (150) send_pair(rand_pair());
        write_reg(REG_PARAM_TOL, 32'hffff_ffff);
        write_reg(REG_SPARE_A, $urandom());
        write_reg(REG_SPARE_B, $urandom());
        write_reg(REG_AREA_TOL, 32'd1 << 20);
        repeat (150) send_pair(rand_pair());
    endtask

    task automatic test_backpressure;
        hold_cycles = 300;
        repeat (120) send_pair(rand_pair());
    endtask

    task automatic test_random;
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(REG_AREA_TOL, (ph == 0) ? 32'd1 : $urandom_range(1 << 16));
            write_reg(REG_PARAM_TOL, (ph == 0) ? 32'd1 : $urandom_range(1 << 24));
            no_idle = (ph == 2);
            repeat (250) send_pair(rand_pair());
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_AREA_TOL;
        cfg_data = '0;
        area_tol = 32'd1;
        param_tol = 30'd1;
        fail_count = 0;
        hold_cycles = 0;
        no_idle = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_tolerances();
        test_random();
        drain();
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/segi_pkg.sv
hw/rtl/segi_front.sv
hw/rtl/segi_div_cell.sv
hw/rtl/segi_back.sv
hw/rtl/segment_intersection_2d.sv
verif/tb_top.sv
